// File: hw/rtl/lgg_pkg.sv
// Shared types and constants for the life generation grid.
// Holds field widths, opcodes, register indexes and the controller states.
// No dependencies.
package lgg_pkg;

  localparam int OPCODE_W    = 2;
  localparam int POS_W       = 7;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int GEN_W       = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    ST_CLEAR      = 7'b0000001,
    ST_IDLE       = 7'b0000010,
    ST_CELL       = 7'b0000100,
    ST_STEP_PRIME = 7'b0001000,
    ST_STEP_LOAD  = 7'b0010000,
    ST_STEP_WRITE = 7'b0100000,
    ST_DONE       = 7'b1000000
  } state_t;

endpackage

// File: hw/rtl/lgg_row_rule.sv
// Applies the B3/S23 rule to one grid row from the rows above, at and below it.
// Columns at or beyond the active width count as dead and keep their stored bits.
// Standalone; instantiated by life_generation_grid.
module lgg_row_rule #(
  parameter int MAX_WIDTH = 128,
  parameter int AW_W      = $clog2(MAX_WIDTH + 1)
) (
  input  logic [MAX_WIDTH-1:0] prev_i,
  input  logic [MAX_WIDTH-1:0] cur_i,
  input  logic [MAX_WIDTH-1:0] next_i,
  input  logic [AW_W-1:0]      act_w_i,
  output logic [MAX_WIDTH-1:0] row_o
);

  logic [MAX_WIDTH-1:0] colmask;
  logic [MAX_WIDTH+1:0] pm;
  logic [MAX_WIDTH+1:0] cm;
  logic [MAX_WIDTH+1:0] nm;

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      colmask[c] = (c < int'(act_w_i));
    end
    pm = {1'b0, prev_i & colmask, 1'b0};
    cm = {1'b0, cur_i & colmask, 1'b0};
    nm = {1'b0, next_i & colmask, 1'b0};
  end

  always_comb begin
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      cnt = 4'(pm[c]) + 4'(pm[c+1]) + 4'(pm[c+2]) + 4'(cm[c]) + 4'(cm[c+2])
          + 4'(nm[c]) + 4'(nm[c+1]) + 4'(nm[c+2]);
      if (colmask[c]) begin
        row_o[c] = (cnt == 4'd3) || (cur_i[c] && (cnt == 4'd2));
      end else begin
        row_o[c] = cur_i[c];
      end
    end
  end

endmodule

// File: hw/rtl/life_generation_grid.sv
// Top level of the life generation grid: controller, row memory and output register.
// Depends on lgg_pkg and lgg_row_rule.
//
// Usage: each input transfer on in_* carries one operation (write cell, read
// cell, advance one generation, clear grid); each produces exactly one output
// transfer on out_* with the cell read back and the generation count.
// The grid is held one row per word in a single memory with a registered read.
// A cell read or write reads the row, then modifies and writes it back or
// picks the bit, then loads the output register and raises out_tvalid. A
// generation step over h active rows (grid_height limited to MAX_HEIGHT) does
// one read and one write of each row before it raises out_tvalid; when h is
// zero it only counts the generation. A clear writes zero to every row before
// it raises out_tvalid. The block works on one item at a time; in_tready is
// high only while it waits for an item.
// After reset the block runs the same clearing pass before it takes its first
// item; configuration writes are taken at any time.
// The output register holds a result until it is taken; while the receiver
// stalls the block may still accept and work on the next item, and waits only
// when a second result is ready.
module life_generation_grid #(
  parameter int MAX_WIDTH  = lgg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [lgg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgg_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode[1:0], x_position[8:2], y_position[15:9], cell_value[16], zero fill
  input  logic [lgg_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cell_state[0], generation[32:1], zero fill
  output logic [lgg_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import lgg_pkg::*;

  localparam int AW_W  = $clog2(MAX_WIDTH + 1);
  localparam int AH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] mem_rdata;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic [ROW_W-1:0]     mem_raddr;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   grid_width_r, grid_width_nxt;
  logic [CFG_W-1:0]   grid_height_r, grid_height_nxt;
  logic [GEN_W-1:0]   gen_r, gen_nxt;
  logic [AH_W-1:0]    row_r, row_nxt;
  logic [ROW_W-1:0]   clr_row_r, clr_row_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;

  op_t                op_r, op_nxt;
  logic [POS_W-1:0]   x_r, x_nxt;
  logic [POS_W-1:0]   y_r, y_nxt;
  logic               val_r, val_nxt;
  logic               res_state_r, res_state_nxt;
  logic [MAX_WIDTH-1:0] prev_r, prev_nxt;
  logic [MAX_WIDTH-1:0] cur_r, cur_nxt;
  logic               out_state_r, out_state_nxt;
  logic [GEN_W-1:0]   out_gen_r, out_gen_nxt;

  logic [AW_W-1:0]      act_w;
  logic [AH_W-1:0]      act_h;
  logic [AH_W-1:0]      row_plus;
  logic [MAX_WIDTH-1:0] next_row;
  logic [MAX_WIDTH-1:0] rule_row;
  logic                 in_grid;
  logic [COL_W-1:0]     col;
  logic                 out_load;
  op_t                  in_op;
  logic                 in_xfer;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= grid_mem[mem_raddr];
  end

  always_comb begin
    if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      act_w = AW_W'(MAX_WIDTH);
    end else begin
      act_w = AW_W'(grid_width_r);
    end
    if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      act_h = AH_W'(MAX_HEIGHT);
    end else begin
      act_h = AH_W'(grid_height_r);
    end
  end

  assign row_plus = row_r + AH_W'(1);
  assign next_row = (row_plus < act_h) ? mem_rdata : '0;
  assign in_grid  = (32'(x_r) < 32'(act_w)) && (32'(y_r) < 32'(act_h));
  assign col      = COL_W'(x_r);
  assign in_op    = op_t'(in_tdata[1:0]);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer  = in_tvalid && in_tready;

  lgg_row_rule #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW_W      (AW_W)
  ) u_rule (
    .prev_i  (prev_r),
    .cur_i   (cur_r),
    .next_i  (next_row),
    .act_w_i (act_w),
    .row_o   (rule_row)
  );

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_wen) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_wdata;
        REG_GRID_HEIGHT: grid_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    row_nxt       = row_r;
    clr_row_nxt   = clr_row_r;
    clr_reply_nxt = clr_reply_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    val_nxt       = val_r;
    res_state_nxt = res_state_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_row_r;
    mem_wdata     = '0;
    mem_raddr     = ROW_W'(row_plus);

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(MAX_HEIGHT - 1)) begin
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = (in_op == OP_STEP) ? '0 : ROW_W'(in_tdata[15:9]);
        if (in_xfer) begin
          op_nxt        = in_op;
          x_nxt         = in_tdata[8:2];
          y_nxt         = in_tdata[15:9];
          val_nxt       = in_tdata[16];
          res_state_nxt = 1'b0;
          case (in_op)
            OP_WRITE, OP_READ: state_nxt = ST_CELL;
            OP_STEP: begin
              row_nxt  = '0;
              prev_nxt = '0;
              if (act_h == '0) begin
                gen_nxt   = gen_r + GEN_W'(1);
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_STEP_PRIME;
              end
            end
            OP_CLEAR: begin
              clr_row_nxt   = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CELL: begin
        mem_waddr = ROW_W'(y_r);
        mem_wdata = mem_rdata;
        mem_wdata[col] = val_r;
        if (in_grid) begin
          if (op_r == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            res_state_nxt = mem_rdata[col];
          end
        end
        state_nxt = ST_DONE;
      end
      ST_STEP_PRIME: begin
        cur_nxt   = mem_rdata;
        state_nxt = ST_STEP_LOAD;
      end
      ST_STEP_LOAD: begin
        state_nxt = ST_STEP_WRITE;
      end
      ST_STEP_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = ROW_W'(row_r);
        mem_wdata = rule_row;
        prev_nxt  = cur_r;
        cur_nxt   = next_row;
        row_nxt   = row_plus;
        if (row_plus == act_h) begin
          gen_nxt   = gen_r + GEN_W'(1);
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_STEP_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_state_nxt = out_state_r;
    out_gen_nxt   = out_gen_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_state_nxt  = res_state_r;
      out_gen_nxt    = gen_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      grid_width_r  <= CFG_SIZE_RESET;
      grid_height_r <= CFG_SIZE_RESET;
      gen_r         <= '0;
      row_r         <= '0;
      clr_row_r     <= '0;
      clr_reply_r   <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      gen_r         <= gen_nxt;
      row_r         <= row_nxt;
      clr_row_r     <= clr_row_nxt;
      clr_reply_r   <= clr_reply_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    val_r       <= val_nxt;
    res_state_r <= res_state_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    out_state_r <= out_state_nxt;
    out_gen_r   <= out_gen_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - GEN_W - 1){1'b0}}, out_gen_r, out_state_r};

  a_gen_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (gen_r != $past(gen_r)) |->
      $past(state_r == ST_STEP_WRITE || state_r == ST_IDLE))
    else $error("generation counter changed outside a step");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE && state_r != ST_DONE))
    else $error("grid memory written while no operation runs");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("pending result overwritten");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("item accepted without entering its operation");

endmodule
